>>> rtl/link_watchdog_emergency_latch_top_macros.svh
// assertion helpers used by the rtl core
`ifndef LINK_WATCHDOG_EMERGENCY_LATCH_TOP_MACROS_SVH
`define LINK_WATCHDOG_EMERGENCY_LATCH_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define LWEL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LWEL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lwel_pkg.sv
`timescale 1ns / 1ps

package lwel_pkg;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_FRAME  = 3'd1;
  localparam logic [2:0] OP_DUP    = 3'd2;
  localparam logic [2:0] OP_REJECT = 3'd3;
  localparam logic [2:0] OP_FAULT  = 3'd4;

  localparam logic [2:0] MODE_STARTUP = 3'd0;
  localparam logic [2:0] MODE_ONLINE  = 3'd1;
  localparam logic [2:0] MODE_TIMEOUT = 3'd2;
  localparam logic [2:0] MODE_EMERG   = 3'd3;
  localparam logic [2:0] MODE_FAULT   = 3'd4;

  localparam logic [2:0] WHY_NONE       = 3'd0;
  localparam logic [2:0] WHY_FAULT      = 3'd1;
  localparam logic [2:0] WHY_EMERG      = 3'd2;
  localparam logic [2:0] WHY_NO_FRAME   = 3'd3;
  localparam logic [2:0] WHY_FRAME_ERR  = 3'd4;
  localparam logic [2:0] WHY_TIMEOUT    = 3'd5;
  localparam logic [2:0] WHY_DISCONNECT = 3'd6;

  localparam logic [1:0] REG_RECOVERY_FRAMES   = 2'd0;
  localparam logic [1:0] REG_TIMEOUT_MS        = 2'd1;
  localparam logic [1:0] REG_FRAME_ERROR_LIMIT = 2'd2;

  localparam logic [7:0]  RECOVERY_FRAMES_RST   = 8'd5;
  localparam logic [15:0] TIMEOUT_MS_RST        = 16'd500;
  localparam logic [15:0] FRAME_ERROR_LIMIT_RST = 16'd10;

  localparam logic [7:0]  GOOD_RUN_MAX   = 8'hFF;
  localparam logic [15:0] REJECT_RUN_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [31:0]        time_ms;
    logic               emergency;
    logic               connected;
    logic signed [15:0] speed_left;
    logic signed [15:0] speed_right;
    logic signed [15:0] axis_up_down;
    logic signed [15:0] axis_left_right;
    logic [31:0]        fault_bits;
  } item_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [2:0]         no_input_reason;
    logic               drive_enable;
    logic signed [15:0] target_left;
    logic signed [15:0] target_right;
    logic signed [15:0] shown_up_down;
    logic signed [15:0] shown_left_right;
    logic [7:0]         recovery_left;
    logic [31:0]        frame_age_ms;
    logic               timeout_entered;
    logic [15:0]        timeout_total;
    logic [31:0]        fault_flags;
  } result_t;

  typedef struct packed {
    logic [7:0]  recovery_frames;
    logic [15:0] timeout_ms;
    logic [15:0] frame_error_limit;
  } cfg_t;

  // beat handed from one stage to the next
  typedef struct packed {
    logic  valid;
    item_t item;
  } item_beat_t;

  typedef struct packed {
    logic    load;
    result_t result;
  } result_beat_t;

endpackage

>>> rtl/link_watchdog_emergency_latch_top.sv
`timescale 1ns / 1ps
// channel   handshake                  payload
// item      item_valid / item_stall    item (item_t)
// result    result_valid / result_stall result (result_t)
// cfg       cfg_valid / cfg_ready      cfg_index, cfg_data
//
// one beat per cycle sustained while result_stall stays low; an item is taken into the
// input register, then loaded with the state update into the result register once it is free
// state and the result register update together in one pass
// rst is synchronous; it empties both registers and restores the cfg defaults
// a stalled result holds; the input register then fills and item_stall rises

module link_watchdog_emergency_latch_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  lwel_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output lwel_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import lwel_pkg::*;

  cfg_t         cfg;
  item_beat_t   held;
  result_beat_t beat;
  logic         fire;
  logic         out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.recovery_frames   <= RECOVERY_FRAMES_RST;
      cfg.timeout_ms        <= TIMEOUT_MS_RST;
      cfg.frame_error_limit <= FRAME_ERROR_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RECOVERY_FRAMES:   cfg.recovery_frames   <= cfg_data[7:0];
        REG_TIMEOUT_MS:        cfg.timeout_ms        <= cfg_data;
        REG_FRAME_ERROR_LIMIT: cfg.frame_error_limit <= cfg_data;
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  lwel_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .fire       (fire),
    .held       (held)
  );

  lwel_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .held     (held),
    .out_free (out_free),
    .fire     (fire),
    .beat     (beat)
  );

  lwel_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .beat         (beat),
    .out_free     (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> rtl/lwel_in_stage.sv
`timescale 1ns / 1ps

module lwel_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  lwel_pkg::item_t    item,
  input  logic               fire,
  output lwel_pkg::item_beat_t held
);
  import lwel_pkg::*;

  logic  hold_valid;
  logic  hold_valid_next;
  item_t hold_item;
  logic  take;

  assign item_stall      = hold_valid & ~fire;
  assign take            = item_valid & ~item_stall;
  assign hold_valid_next = take | (hold_valid & ~fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_item <= item;
    end
  end

  assign held.valid = hold_valid;
  assign held.item  = hold_item;

endmodule

>>> rtl/lwel_core.sv
`timescale 1ns / 1ps
`include "link_watchdog_emergency_latch_top_macros.svh"

module lwel_core (
  input  logic                   clk,
  input  logic                   rst,
  input  lwel_pkg::cfg_t         cfg,
  input  lwel_pkg::item_beat_t   held,
  input  logic                   out_free,
  output logic                   fire,
  output lwel_pkg::result_beat_t beat
);
  import lwel_pkg::*;

  typedef struct packed {
    logic [2:0]  cur_mode;
    logic [2:0]  prior_mode;
    logic        latched;
    logic [7:0]  good_run;
    logic [15:0] reject_run;
    logic        seen_frame;
    logic [31:0] last_good_ms;
    logic        link_present;
    logic [15:0] req_left;
    logic [15:0] req_right;
    logic [15:0] req_up_down;
    logic [15:0] req_left_right;
    logic [31:0] fault_store;
    logic [15:0] timeout_count;
  } lwel_state_t;

  lwel_state_t st;
  lwel_state_t st_next;
  item_t       it;
  logic [31:0] age_diff;
  logic [7:0]  good_inc;
  logic [2:0]  tick_mode;
  logic        entered;
  logic [2:0]  why;
  logic        drive;
  result_t     res;

  assign it   = held.item;
  assign fire = held.valid & out_free;

  assign age_diff = it.time_ms - st.last_good_ms;
  assign good_inc = (st.good_run != GOOD_RUN_MAX) ? st.good_run + 8'd1 : st.good_run;

  always_comb begin
    if (st.fault_store != 32'd0) begin
      tick_mode = MODE_FAULT;
    end else if (st.latched) begin
      tick_mode = MODE_EMERG;
    end else if (!st.seen_frame) begin
      tick_mode = MODE_STARTUP;
    end else if (age_diff >= {16'd0, cfg.timeout_ms}) begin
      tick_mode = MODE_TIMEOUT;
    end else begin
      tick_mode = MODE_ONLINE;
    end
  end

  always_comb begin
    st_next = st;
    entered = 1'b0;
    case (it.opcode)
      OP_TICK: begin
        st_next.cur_mode   = tick_mode;
        st_next.prior_mode = tick_mode;
        if (tick_mode == MODE_TIMEOUT && st.prior_mode != MODE_TIMEOUT) begin
          entered                = 1'b1;
          st_next.timeout_count  = st.timeout_count + 16'd1;
          st_next.req_left       = 16'd0;
          st_next.req_right      = 16'd0;
          st_next.req_up_down    = 16'd0;
          st_next.req_left_right = 16'd0;
        end
        if (!(tick_mode == MODE_ONLINE && st.link_present)) begin
          st_next.req_up_down    = 16'd0;
          st_next.req_left_right = 16'd0;
        end
      end
      OP_FRAME: begin
        st_next.last_good_ms = it.time_ms;
        st_next.seen_frame   = 1'b1;
        st_next.reject_run   = 16'd0;
        st_next.link_present = it.connected;
        if (it.emergency) begin
          st_next.latched        = 1'b1;
          st_next.good_run       = 8'd0;
          st_next.req_left       = 16'd0;
          st_next.req_right      = 16'd0;
          st_next.req_up_down    = 16'd0;
          st_next.req_left_right = 16'd0;
        end else if (st.latched) begin
          if (good_inc >= cfg.recovery_frames) begin
            st_next.latched  = 1'b0;
            st_next.good_run = 8'd0;
          end else begin
            st_next.good_run = good_inc;
          end
          st_next.req_left       = 16'd0;
          st_next.req_right      = 16'd0;
          st_next.req_up_down    = 16'd0;
          st_next.req_left_right = 16'd0;
        end else begin
          st_next.good_run       = 8'd0;
          st_next.req_left       = it.speed_left;
          st_next.req_right      = it.speed_right;
          st_next.req_up_down    = it.axis_up_down;
          st_next.req_left_right = it.axis_left_right;
        end
      end
      OP_REJECT: begin
        st_next.good_run = 8'd0;
        if (st.reject_run != REJECT_RUN_MAX) begin
          st_next.reject_run = st.reject_run + 16'd1;
        end
      end
      OP_FAULT: begin
        st_next.fault_store = st.fault_store | it.fault_bits;
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  always_comb begin
    case (st_next.cur_mode)
      MODE_FAULT:   why = WHY_FAULT;
      MODE_EMERG:   why = WHY_EMERG;
      MODE_STARTUP: why = WHY_NO_FRAME;
      MODE_TIMEOUT: begin
        why = (st_next.reject_run >= cfg.frame_error_limit) ? WHY_FRAME_ERR : WHY_TIMEOUT;
      end
      default:      why = st_next.link_present ? WHY_NONE : WHY_DISCONNECT;
    endcase
  end

  assign drive = (st_next.cur_mode == MODE_ONLINE) && st_next.link_present &&
                 (st_next.fault_store == 32'd0);

  always_comb begin
    res.mode             = st_next.cur_mode;
    res.no_input_reason  = why;
    res.drive_enable     = drive;
    res.target_left      = drive ? st_next.req_left : 16'sd0;
    res.target_right     = drive ? st_next.req_right : 16'sd0;
    res.shown_up_down    = (why == WHY_NONE) ? st_next.req_up_down : 16'sd0;
    res.shown_left_right = (why == WHY_NONE) ? st_next.req_left_right : 16'sd0;
    res.recovery_left    = (st_next.latched && cfg.recovery_frames > st_next.good_run) ?
                           cfg.recovery_frames - st_next.good_run : 8'd0;
    if (it.opcode == OP_FRAME) begin
      res.frame_age_ms = 32'd0;
    end else begin
      res.frame_age_ms = st.seen_frame ? age_diff : it.time_ms;
    end
    res.timeout_entered  = entered;
    res.timeout_total    = st_next.timeout_count;
    res.fault_flags      = st_next.fault_store;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  assign beat.load   = fire;
  assign beat.result = res;

  `LWEL_ASSERT_NOW(a_unlatched_run_clear, clk, rst, !st.latched, st.good_run == 8'd0,
    "good run left over while unlatched")
  `LWEL_ASSERT_NEXT(a_fault_wins, clk, rst,
    fire && it.opcode == OP_TICK && st.fault_store != 32'd0, st.cur_mode == MODE_FAULT,
    "tick with stored fault did not select fault mode")
  `LWEL_ASSERT_NEXT(a_entry_counted, clk, rst, fire && entered,
    st.prior_mode == MODE_TIMEOUT && st.timeout_count == $past(st.timeout_count) + 16'd1,
    "timeout entry not recorded")

endmodule

>>> rtl/lwel_out_stage.sv
`timescale 1ns / 1ps

module lwel_out_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  lwel_pkg::result_beat_t beat,
  output logic                   out_free,
  output logic                   result_valid,
  input  logic                   result_stall,
  output lwel_pkg::result_t      result
);
  import lwel_pkg::*;

  logic    full;
  logic    full_next;
  result_t data;

  assign out_free  = ~full | ~result_stall;
  assign full_next = beat.load | (full & result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (beat.load) begin
      data <= beat.result;
    end
  end

  assign result_valid = full;
  assign result       = data;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import lwel_pkg::*;

  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int PRINT_LIMIT = 40;

  logic        clk;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_RECOVERY_FRAMES;
  logic [15:0] cfg_data = '0;

  // watchdog model state
  cfg_t               regs;
  logic [2:0]         cur_mode = MODE_STARTUP;
  logic [2:0]         prev_mode = MODE_STARTUP;
  logic               latch_on = 1'b0;
  logic [7:0]         good_cnt = '0;
  logic [15:0]        reject_cnt = '0;
  logic               frame_seen = 1'b0;
  logic [31:0]        last_frame_ms = '0;
  logic               link_up = 1'b0;
  logic signed [15:0] rq_left = '0;
  logic signed [15:0] rq_right = '0;
  logic signed [15:0] rq_ud = '0;
  logic signed [15:0] rq_lr = '0;
  logic [31:0]        fault_acc = '0;
  logic [15:0]        timeouts = '0;

  result_t     pending_results[$];
  result_t     want_r;
  int          fail_count = 0;
  int          quiet_cycles = 0;
  int          snd_pct = 0;
  int          rcv_pct = 0;
  int          phase_snd = 0;
  int          phase_rcv = 0;
  bit          item_up = 1'b0;
  bit          cfg_up = 1'b0;
  logic [31:0] now_ms = '0;

  link_watchdog_emergency_latch_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void drop_requests();
    rq_left = '0;
    rq_right = '0;
    rq_ud = '0;
    rq_lr = '0;
  endfunction

  function automatic result_t step_watchdog(input item_t it);
    result_t    r;
    logic [2:0] m;
    logic [2:0] why;
    logic       hit;
    logic       drive;
    hit = 1'b0;
    case (it.opcode)
      OP_TICK: begin
        if (fault_acc != '0) m = MODE_FAULT;
        else if (latch_on) m = MODE_EMERG;
        else if (!frame_seen) m = MODE_STARTUP;
        else if ((it.time_ms - last_frame_ms) >= 32'(regs.timeout_ms)) m = MODE_TIMEOUT;
        else m = MODE_ONLINE;
        cur_mode = m;
        if (m == MODE_TIMEOUT && prev_mode != MODE_TIMEOUT) begin
          timeouts = timeouts + 16'd1;
          hit = 1'b1;
          drop_requests();
        end
        if (!(m == MODE_ONLINE && link_up)) begin
          rq_ud = '0;
          rq_lr = '0;
        end
        prev_mode = m;
      end
      OP_FRAME: begin
        last_frame_ms = it.time_ms;
        frame_seen = 1'b1;
        reject_cnt = '0;
        link_up = it.connected;
        if (it.emergency) begin
          latch_on = 1'b1;
          good_cnt = '0;
          drop_requests();
        end else if (latch_on) begin
          if (good_cnt != GOOD_RUN_MAX) good_cnt = good_cnt + 8'd1;
          if (good_cnt >= regs.recovery_frames) begin
            latch_on = 1'b0;
            good_cnt = '0;
          end
          drop_requests();
        end else begin
          good_cnt = '0;
          rq_left = it.speed_left;
          rq_right = it.speed_right;
          rq_ud = it.axis_up_down;
          rq_lr = it.axis_left_right;
        end
      end
      OP_REJECT: begin
        good_cnt = '0;
        if (reject_cnt != REJECT_RUN_MAX) reject_cnt = reject_cnt + 16'd1;
      end
      OP_FAULT: fault_acc = fault_acc | it.fault_bits;
      default: ;
    endcase

    if (cur_mode == MODE_FAULT) why = WHY_FAULT;
    else if (cur_mode == MODE_EMERG) why = WHY_EMERG;
    else if (cur_mode == MODE_STARTUP) why = WHY_NO_FRAME;
    else if (cur_mode == MODE_TIMEOUT)
      why = (reject_cnt >= regs.frame_error_limit) ? WHY_FRAME_ERR : WHY_TIMEOUT;
    else if (!link_up) why = WHY_DISCONNECT;
    else why = WHY_NONE;
    drive = (cur_mode == MODE_ONLINE) && link_up && (fault_acc == '0);

    r.mode = cur_mode;
    r.no_input_reason = why;
    r.drive_enable = drive;
    r.target_left = drive ? rq_left : '0;
    r.target_right = drive ? rq_right : '0;
    r.shown_up_down = (why == WHY_NONE) ? rq_ud : '0;
    r.shown_left_right = (why == WHY_NONE) ? rq_lr : '0;
    r.recovery_left = (latch_on && regs.recovery_frames > good_cnt) ?
                      regs.recovery_frames - good_cnt : '0;
    r.frame_age_ms = frame_seen ? it.time_ms - last_frame_ms : it.time_ms;
    r.timeout_entered = hit;
    r.timeout_total = timeouts;
    r.fault_flags = fault_acc;
    return r;
  endfunction

  task automatic cmp_field(input string name, input logic [31:0] want,
                           input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= PRINT_LIMIT)
        $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result(input result_t want, input result_t got);
    cmp_field("mode", want.mode, got.mode);
    cmp_field("no_input_reason", want.no_input_reason, got.no_input_reason);
    cmp_field("drive_enable", want.drive_enable, got.drive_enable);
    cmp_field("target_left", want.target_left, got.target_left);
    cmp_field("target_right", want.target_right, got.target_right);
    cmp_field("shown_up_down", want.shown_up_down, got.shown_up_down);
    cmp_field("shown_left_right", want.shown_left_right, got.shown_left_right);
    cmp_field("recovery_left", want.recovery_left, got.recovery_left);
    cmp_field("frame_age_ms", want.frame_age_ms, got.frame_age_ms);
    cmp_field("timeout_entered", want.timeout_entered, got.timeout_entered);
    cmp_field("timeout_total", want.timeout_total, got.timeout_total);
    cmp_field("fault_flags", want.fault_flags, got.fault_flags);
  endtask

  // result side: random stall and compare against the oldest expectation
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < rcv_pct);
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
          $display("%0t unexpected result: expected none actual %h", $time, result);
      end else begin
        want_r = pending_results.pop_front();
        check_result(want_r, result);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put_item_valid(input bit v);
    if (item_up != v) begin
      item_valid <= v;
      item_up = v;
    end
  endtask

  task automatic put_cfg_valid(input bit v);
    if (cfg_up != v) begin
      cfg_valid <= v;
      cfg_up = v;
    end
  endtask

  function automatic item_t make_item(input logic [2:0] op, input logic [31:0] t);
    item_t it;
    it.opcode = op;
    it.time_ms = t;
    it.emergency = 1'($urandom_range(1));
    it.connected = 1'($urandom_range(1));
    it.speed_left = 16'($urandom);
    it.speed_right = 16'($urandom);
    it.axis_up_down = 16'($urandom);
    it.axis_left_right = 16'($urandom);
    it.fault_bits = (op == OP_FAULT) ? 32'd0 : $urandom;
    return it;
  endfunction

  function automatic item_t make_frame(input logic [31:0] t, input logic em,
                                       input logic cn);
    item_t it;
    it = make_item(OP_FRAME, t);
    it.emergency = em;
    it.connected = cn;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < snd_pct) gap++;
    put_cfg_valid(1'b0);
    if (gap > 0) begin
      put_item_valid(1'b0);
      repeat (gap) @(posedge clk);
    end
    put_item_valid(1'b1);
    item <= it;
    do @(posedge clk); while (item_stall);
    pending_results.push_back(step_watchdog(it));
  endtask

  task automatic send_op(input logic [2:0] op, input logic [31:0] t);
    send_item(make_item(op, t));
  endtask

  task automatic wait_drained();
    if (pending_results.size() != 0) begin
      put_item_valid(1'b0);
      put_cfg_valid(1'b0);
      while (pending_results.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    put_item_valid(1'b0);
    put_cfg_valid(1'b1);
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RECOVERY_FRAMES:   regs.recovery_frames = data[7:0];
      REG_TIMEOUT_MS:        regs.timeout_ms = data;
      REG_FRAME_ERROR_LIMIT: regs.frame_error_limit = data;
      default: ;
    endcase
  endtask

  task automatic test_directed();
    item_t it;
    send_op(OP_TICK, 32'd0);
    send_op(OP_DUP, 32'd7);
    for (int k = OP_UNUSED_FIRST; k <= OP_UNUSED_LAST; k++) send_op(3'(k), 32'd8);
    send_op(OP_FAULT, 32'd9);
    send_op(OP_REJECT, 32'd10);
    it = make_frame(32'd1000, 1'b0, 1'b1);
    it.speed_left = 16'h7FFF;
    it.speed_right = 16'h8000;
    it.axis_up_down = 16'h8000;
    it.axis_left_right = 16'h7FFF;
    send_item(it);
    send_op(OP_TICK, 32'd1001);
    it = make_frame(32'd1010, 1'b0, 1'b0);
    it.speed_left = 16'h8000;
    it.speed_right = 16'h7FFF;
    it.axis_up_down = 16'h7FFF;
    it.axis_left_right = 16'h8000;
    send_item(it);
    send_op(OP_TICK, 32'd1011);
    send_item(make_frame(32'd1020, 1'b0, 1'b1));
    send_op(OP_TICK, 32'd1520);
    send_op(OP_TICK, 32'd1600);
    send_item(make_frame(32'd1700, 1'b1, 1'b1));
    send_op(OP_TICK, 32'd1701);
    for (int k = 0; k < 5; k++) send_item(make_frame(32'd1702 + k, 1'b0, 1'b1));
    send_op(OP_TICK, 32'd1710);
    // time wraps between the frame and the tick
    send_item(make_frame(32'hFFFF_FFF0, 1'b0, 1'b1));
    send_op(OP_TICK, 32'h0000_0010);
    now_ms = 32'h0000_0010;
  endtask

  task automatic test_register_corners();
    wait_drained();
    write_reg(REG_RECOVERY_FRAMES, {8'($urandom), 8'd0});
    write_reg(REG_TIMEOUT_MS, 16'd0);
    write_reg(REG_FRAME_ERROR_LIMIT, 16'd0);
    now_ms = now_ms + 32'd100;
    send_item(make_frame(now_ms, 1'b0, 1'b1));
    send_op(OP_TICK, now_ms);
    send_item(make_frame(now_ms, 1'b1, 1'b1));
    send_op(OP_TICK, now_ms);
    send_item(make_frame(now_ms, 1'b0, 1'b1));
    send_op(OP_TICK, now_ms);
    wait_drained();
    write_reg(REG_RECOVERY_FRAMES, {8'($urandom), 8'hFF});
    write_reg(REG_TIMEOUT_MS, 16'hFFFF);
    write_reg(REG_FRAME_ERROR_LIMIT, 16'hFFFF);
    now_ms = now_ms + 32'd3;
    send_item(make_frame(now_ms, 1'b1, 1'b1));
    send_op(OP_TICK, now_ms);
    for (int k = 0; k < 4; k++) send_item(make_frame(now_ms, 1'b0, 1'b1));
    send_op(OP_TICK, now_ms);
    wait_drained();
    // good run already past the new recovery count
    write_reg(REG_RECOVERY_FRAMES, {8'($urandom), 8'd2});
    send_op(OP_TICK, now_ms);
    send_item(make_frame(now_ms, 1'b0, 1'b1));
    send_op(OP_TICK, now_ms + 32'd40);
    now_ms = now_ms + 32'd40;
  endtask

  task automatic test_random_traffic(input int count);
    item_t      it;
    logic [2:0] op;
    int         sent;
    int         pick;
    sent = 0;
    while (sent < count) begin
      if (sent % 60 == 0) begin
        wait_drained();
        write_reg(REG_RECOVERY_FRAMES, {8'($urandom), 8'($urandom_range(1, 8))});
        write_reg(REG_TIMEOUT_MS, 16'($urandom_range(10, 300)));
        write_reg(REG_FRAME_ERROR_LIMIT, 16'($urandom_range(1, 6)));
      end
      pick = $urandom_range(99);
      if (pick < 85) now_ms = now_ms + 32'($urandom_range(0, 30));
      else if (pick < 97) now_ms = now_ms + 32'(regs.timeout_ms) + 32'($urandom_range(0, 50));
      else now_ms = $urandom;
      pick = $urandom_range(99);
      if (pick < 35) op = OP_TICK;
      else if (pick < 75) op = OP_FRAME;
      else if (pick < 82) op = OP_DUP;
      else if (pick < 94) op = OP_REJECT;
      else if (pick < 97) op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      else op = OP_FAULT;
      it = make_item(op, now_ms);
      if (op == OP_FRAME) begin
        it.emergency = ($urandom_range(99) < 7);
        it.connected = ($urandom_range(99) < 85);
      end
      send_item(it);
      sent++;
    end
  endtask

  task automatic test_reject_limit();
    wait_drained();
    write_reg(REG_RECOVERY_FRAMES, 16'd1);
    write_reg(REG_TIMEOUT_MS, 16'd100);
    write_reg(REG_FRAME_ERROR_LIMIT, 16'd4);
    now_ms = now_ms + 32'd10;
    send_item(make_frame(now_ms, 1'b0, 1'b1));
    repeat (3) send_op(OP_REJECT, now_ms);
    now_ms = now_ms + 32'd100;
    send_op(OP_TICK, now_ms);
    send_op(OP_REJECT, now_ms);
    send_op(OP_TICK, now_ms);
    repeat (3) send_op(OP_REJECT, now_ms);
    send_op(OP_TICK, now_ms);
  endtask

  task automatic test_fault_latch();
    item_t it;
    for (int k = 0; k < 4; k++) begin
      now_ms = now_ms + 32'd5;
      it = make_item(OP_FAULT, now_ms);
      it.fault_bits = (k == 0) ? 32'hFFFF_FFFF : $urandom;
      send_item(it);
      send_op(OP_TICK, now_ms);
    end
    test_random_traffic(30);
  endtask

  initial begin
    regs.recovery_frames = RECOVERY_FRAMES_RST;
    regs.timeout_ms = TIMEOUT_MS_RST;
    regs.frame_error_limit = FRAME_ERROR_LIMIT_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    phase_snd = 22;
    phase_rcv = 52;
    snd_pct = phase_snd;
    rcv_pct = phase_rcv;
    test_directed();
    test_register_corners();
    test_random_traffic(220);

    phase_snd = 52;
    phase_rcv = 22;
    snd_pct = phase_snd;
    rcv_pct = phase_rcv;
    test_random_traffic(220);

    phase_snd = 0;
    phase_rcv = 0;
    snd_pct = 0;
    rcv_pct = 0;
    test_random_traffic(220);
    test_reject_limit();
    test_fault_latch();

    wait_drained();
    put_item_valid(1'b0);
    put_cfg_valid(1'b0);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
